// ===== design/srsp_pkg.sv =====
// ----------------------------------------------------------------------------
// srsp_pkg
// Shared types and codes for the sequence record stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srsp_pkg;

    // Parser phase, one-hot
    typedef enum logic [23:0] {
        PH_CNT_HI   = 24'h000001,
        PH_CNT_LO   = 24'h000002,
        PH_OPCODE   = 24'h000004,
        PH_FCOUNT   = 24'h000008,
        PH_FID_HI   = 24'h000010,
        PH_FID_LO   = 24'h000020,
        PH_IF_HI    = 24'h000040,
        PH_IF_LO    = 24'h000080,
        PH_DL_HI    = 24'h000100,
        PH_DL_LO    = 24'h000200,
        PH_ROFF_HI  = 24'h000400,
        PH_ROFF_LO  = 24'h000800,
        PH_MCOUNT   = 24'h001000,
        PH_MERGE    = 24'h002000,
        PH_PRIO     = 24'h004000,
        PH_RIGHT_HI = 24'h008000,
        PH_RIGHT_LO = 24'h010000,
        PH_LEFT_HI  = 24'h020000,
        PH_LEFT_LO  = 24'h040000,
        PH_REPLAYS  = 24'h080000,
        PH_PRE      = 24'h100000,
        PH_POST     = 24'h200000,
        PH_DUP      = 24'h400000,
        PH_DONE     = 24'h800000
    } t_phase;

    typedef enum logic [3:0] {
        EV_COUNT      = 4'd0,
        EV_FRAMECOUNT = 4'd1,
        EV_FRAME      = 4'd2,
        EV_REPLAYOFF  = 4'd3,
        EV_MERGECOUNT = 4'd4,
        EV_MERGE      = 4'd5,
        EV_STRETCH    = 4'd6,
        EV_PRIO       = 4'd7,
        EV_RIGHT      = 4'd8,
        EV_LEFT       = 4'd9,
        EV_REPLAYS    = 4'd10,
        EV_PRE        = 4'd11,
        EV_POST       = 4'd12,
        EV_DUP        = 4'd13,
        EV_END        = 4'd14,
        EV_BADCODE    = 4'd15
    } t_kind;

    localparam logic [7:0] OP_END     = 8'd0;
    localparam logic [7:0] OP_FRAMES  = 8'd1;
    localparam logic [7:0] OP_ROFF    = 8'd2;
    localparam logic [7:0] OP_MERGE   = 8'd3;
    localparam logic [7:0] OP_STRETCH = 8'd4;
    localparam logic [7:0] OP_PRIO    = 8'd5;
    localparam logic [7:0] OP_RIGHT   = 8'd6;
    localparam logic [7:0] OP_LEFT    = 8'd7;
    localparam logic [7:0] OP_REPLAYS = 8'd8;
    localparam logic [7:0] OP_PRE     = 8'd9;
    localparam logic [7:0] OP_POST    = 8'd10;
    localparam logic [7:0] OP_DUP     = 8'd11;

    localparam logic [15:0]       IFRAME_NONE = 16'hFFFF;
    localparam logic signed [16:0] VAL_NEG1   = -17'sd1;
    localparam logic signed [16:0] MOVE_MERGE = 17'sd2;

    // Pending-event mask bits of one burst
    localparam int B_SINGLE = 0;
    localparam int B_FCOUNT = 1;
    localparam int B_FRAME  = 2;
    localparam int B_PRE    = 3;
    localparam int B_POST   = 4;
    localparam int B_END    = 5;
    localparam int NBURST   = 6;

    // Events caused by one byte: none, one plain event or a record-end run
    typedef struct packed {
        logic [NBURST-1:0]  mask;
        logic [15:0]        rec;
        t_kind              kind;
        logic [7:0]         idx;
        logic signed [16:0] main_v;
        logic signed [16:0] ib;
        logic signed [16:0] dl;
    } t_burst;

endpackage

`default_nettype wire

// ===== design/sequence_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// sequence_record_stream_parser
// Byte-stream parser for sequence definition records; turns the records into events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one stream byte per word;
//   i_stream_start marks the count high byte of a new stream and restarts
//   the parser. Output channel (o_valid / i_ready) delivers one event per
//   word; o_last_of_run flags the final event caused by a byte.
//   Timing: an event appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while i_ready is high and each byte
//   yields at most one event. A record-end byte yields one to five
//   events, one per unstalled cycle, and the next byte is taken in the
//   cycle the last of them leaves. The rate is set by the single result
//   register that holds one byte's events; the decode is one registered pass.
//   Reset: synchronous, active low; parser waits for the count high byte
//   and the output is empty.
//   Stall: while i_ready is low the current event holds and o_ready stays
//   low once a result is pending, so no byte is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_record_stream_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [7:0]           i_data_byte,
    input  wire                 i_stream_start,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_record_number,
    output logic [3:0]          o_event_kind,
    output logic [7:0]          o_entry_index,
    output logic signed [16:0]  o_main_value,
    output logic signed [16:0]  o_inbetween_frame,
    output logic signed [16:0]  o_frame_delay,
    output logic                o_last_of_run
);
    import srsp_pkg::*;

    t_burst burst;
    logic   acc;
    logic   free;

    assign o_ready = free;
    assign acc     = i_valid && free;

    srsp_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_data_byte    (i_data_byte),
        .i_stream_start (i_stream_start),
        .o_burst        (burst)
    );

    srsp_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (acc),
        .i_burst           (burst),
        .i_ready           (i_ready),
        .o_free            (free),
        .o_valid           (o_valid),
        .o_record_number   (o_record_number),
        .o_event_kind      (o_event_kind),
        .o_entry_index     (o_entry_index),
        .o_main_value      (o_main_value),
        .o_inbetween_frame (o_inbetween_frame),
        .o_frame_delay     (o_frame_delay),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== design/srsp_decode.sv =====
// ----------------------------------------------------------------------------
// srsp_decode
// Parser state and byte decode; turns one accepted byte into a burst.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_decode (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_acc,
    input  wire [7:0]        i_data_byte,
    input  wire              i_stream_start,
    output srsp_pkg::t_burst o_burst
);
    import srsp_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    logic [15:0] r_total, n_total;
    logic [15:0] r_rec, n_rec, c_rec;
    logic [7:0]  r_hi, n_hi;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_fid, n_fid;
    logic [15:0] r_ib, n_ib;
    logic [7:0]  r_frames, n_frames;
    logic        r_merge, n_merge;
    logic        r_pre, n_pre;
    logic        r_post, n_post;

    logic [15:0]        word;
    logic [7:0]         pos_inc;
    logic [15:0]        rec_inc;
    logic signed [16:0] word_s;
    logic signed [16:0] byte_s;
    t_burst             bu;

    assign word    = {r_hi, i_data_byte};
    assign pos_inc = r_pos + 8'd1;
    assign rec_inc = r_rec + 16'd1;
    assign word_s  = {1'b0, word};
    assign byte_s  = {9'd0, i_data_byte};
    assign c_phase = i_stream_start ? PH_CNT_HI : r_phase;
    assign c_rec   = i_stream_start ? 16'd0 : r_rec;

    always_comb begin
        n_phase  = c_phase;
        n_total  = i_stream_start ? 16'd0 : r_total;
        n_rec    = c_rec;
        n_hi     = i_stream_start ? 8'd0 : r_hi;
        n_len    = i_stream_start ? 8'd0 : r_len;
        n_pos    = i_stream_start ? 8'd0 : r_pos;
        n_fid    = i_stream_start ? 16'd0 : r_fid;
        n_ib     = i_stream_start ? 16'd0 : r_ib;
        n_frames = i_stream_start ? 8'd0 : r_frames;
        n_merge  = i_stream_start ? 1'b0 : r_merge;
        n_pre    = i_stream_start ? 1'b0 : r_pre;
        n_post   = i_stream_start ? 1'b0 : r_post;

        bu        = '0;
        bu.rec    = c_rec;
        bu.kind   = EV_COUNT;

        unique case (c_phase)
            PH_CNT_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_CNT_LO;
            end
            PH_CNT_LO: begin
                n_total  = word;
                n_rec    = 16'd0;
                n_len    = 8'd0;
                n_pos    = 8'd0;
                n_fid    = 16'd0;
                n_ib     = 16'd0;
                n_frames = 8'd0;
                n_merge  = 1'b0;
                n_pre    = 1'b0;
                n_post   = 1'b0;
                bu.mask[B_SINGLE] = 1'b1;
                bu.rec    = 16'd0;
                bu.kind   = EV_COUNT;
                bu.main_v = word_s;
                n_phase   = (word == 16'd0) ? PH_DONE : PH_OPCODE;
            end
            PH_OPCODE: begin
                unique case (i_data_byte)
                    OP_END: begin
                        bu.mask[B_FCOUNT] = (r_frames == 8'd0);
                        bu.mask[B_FRAME]  = (r_frames == 8'd0);
                        bu.mask[B_PRE]    = !r_pre;
                        bu.mask[B_POST]   = !r_post;
                        bu.mask[B_END]    = 1'b1;
                        bu.main_v = r_merge ? MOVE_MERGE : 17'sd0;
                        n_rec    = rec_inc;
                        n_len    = 8'd0;
                        n_pos    = 8'd0;
                        n_fid    = 16'd0;
                        n_ib     = 16'd0;
                        n_frames = 8'd0;
                        n_merge  = 1'b0;
                        n_pre    = 1'b0;
                        n_post   = 1'b0;
                        n_phase  = (rec_inc >= r_total) ? PH_DONE : PH_OPCODE;
                    end
                    OP_FRAMES:  n_phase = PH_FCOUNT;
                    OP_ROFF:    n_phase = PH_ROFF_HI;
                    OP_MERGE:   n_phase = PH_MCOUNT;
                    OP_STRETCH: begin
                        bu.mask[B_SINGLE] = 1'b1;
                        bu.kind   = EV_STRETCH;
                        bu.main_v = 17'sd1;
                    end
                    OP_PRIO:    n_phase = PH_PRIO;
                    OP_RIGHT:   n_phase = PH_RIGHT_HI;
                    OP_LEFT:    n_phase = PH_LEFT_HI;
                    OP_REPLAYS: n_phase = PH_REPLAYS;
                    OP_PRE:     n_phase = PH_PRE;
                    OP_POST:    n_phase = PH_POST;
                    OP_DUP:     n_phase = PH_DUP;
                    default: begin
                        bu.mask[B_SINGLE] = 1'b1;
                        bu.kind   = EV_BADCODE;
                        bu.main_v = byte_s;
                    end
                endcase
            end
            PH_FCOUNT: begin
                n_frames = i_data_byte;
                n_len    = i_data_byte;
                n_pos    = 8'd0;
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_FRAMECOUNT;
                bu.main_v = byte_s;
                n_phase   = (i_data_byte == 8'd0) ? PH_OPCODE : PH_FID_HI;
            end
            PH_FID_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_FID_LO;
            end
            PH_FID_LO: begin
                n_fid   = word;
                n_phase = PH_IF_HI;
            end
            PH_IF_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_IF_LO;
            end
            PH_IF_LO: begin
                n_ib    = word;
                n_phase = PH_DL_HI;
            end
            PH_DL_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_DL_LO;
            end
            PH_DL_LO: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_FRAME;
                bu.idx    = r_pos;
                bu.main_v = {1'b0, r_fid};
                bu.ib     = (r_ib == IFRAME_NONE) ? VAL_NEG1 : {1'b0, r_ib};
                bu.dl     = word_s;
                n_pos     = pos_inc;
                n_phase   = (pos_inc >= r_len) ? PH_OPCODE : PH_FID_HI;
            end
            PH_ROFF_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_ROFF_LO;
            end
            PH_ROFF_LO: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_REPLAYOFF;
                bu.main_v = word_s;
                n_phase   = PH_OPCODE;
            end
            PH_MCOUNT: begin
                n_merge = 1'b1;
                n_len   = i_data_byte;
                n_pos   = 8'd0;
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_MERGECOUNT;
                bu.main_v = byte_s;
                n_phase   = (i_data_byte == 8'd0) ? PH_OPCODE : PH_MERGE;
            end
            PH_MERGE: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_MERGE;
                bu.idx    = r_pos;
                bu.main_v = byte_s;
                n_pos     = pos_inc;
                n_phase   = (pos_inc >= r_len) ? PH_OPCODE : PH_MERGE;
            end
            PH_PRIO: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_PRIO;
                bu.main_v = byte_s;
                n_phase   = PH_OPCODE;
            end
            PH_RIGHT_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_RIGHT_LO;
            end
            PH_RIGHT_LO: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_RIGHT;
                bu.main_v = word_s;
                n_phase   = PH_OPCODE;
            end
            PH_LEFT_HI: begin
                n_hi    = i_data_byte;
                n_phase = PH_LEFT_LO;
            end
            PH_LEFT_LO: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_LEFT;
                bu.main_v = word_s;
                n_phase   = PH_OPCODE;
            end
            PH_REPLAYS: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_REPLAYS;
                bu.main_v = byte_s;
                n_phase   = PH_OPCODE;
            end
            PH_PRE: begin
                n_pre = 1'b1;
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_PRE;
                bu.main_v = byte_s;
                n_phase   = PH_OPCODE;
            end
            PH_POST: begin
                n_post = 1'b1;
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_POST;
                bu.main_v = byte_s;
                n_phase   = PH_OPCODE;
            end
            PH_DUP: begin
                bu.mask[B_SINGLE] = 1'b1;
                bu.kind   = EV_DUP;
                bu.main_v = byte_s;
                n_phase   = PH_OPCODE;
            end
            default: begin
                // stream finished: drop bytes until the next start
                n_phase = PH_DONE;
            end
        endcase
    end

    assign o_burst = bu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CNT_HI;
            r_total  <= '0;
            r_rec    <= '0;
            r_hi     <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_fid    <= '0;
            r_ib     <= '0;
            r_frames <= '0;
            r_merge  <= 1'b0;
            r_pre    <= 1'b0;
            r_post   <= 1'b0;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_total  <= n_total;
            r_rec    <= n_rec;
            r_hi     <= n_hi;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_fid    <= n_fid;
            r_ib     <= n_ib;
            r_frames <= n_frames;
            r_merge  <= n_merge;
            r_pre    <= n_pre;
            r_post   <= n_post;
        end
    end

endmodule

`default_nettype wire

// ===== design/srsp_emit.sv =====
// ----------------------------------------------------------------------------
// srsp_emit
// Result register: holds one burst and plays its events out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_emit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  srsp_pkg::t_burst    i_burst,
    input  wire                 i_ready,
    output logic                o_free,
    output logic                o_valid,
    output logic [15:0]         o_record_number,
    output logic [3:0]          o_event_kind,
    output logic [7:0]          o_entry_index,
    output logic signed [16:0]  o_main_value,
    output logic signed [16:0]  o_inbetween_frame,
    output logic signed [16:0]  o_frame_delay,
    output logic                o_last_of_run
);
    import srsp_pkg::*;

    logic [NBURST-1:0]  r_mask, n_mask;
    t_burst             r_bu;
    logic [NBURST-1:0]  low;
    logic [NBURST-1:0]  rest;
    t_kind              kind;

    assign low     = r_mask & (~r_mask + {{(NBURST-1){1'b0}}, 1'b1});
    assign rest    = r_mask & ~low;
    assign o_valid = |r_mask;
    assign o_last_of_run = (rest == '0);
    // take a new byte when empty or once the final event of this burst leaves
    assign o_free  = !o_valid || (i_ready && o_last_of_run);

    always_comb begin
        kind              = r_bu.kind;
        o_entry_index     = 8'd0;
        o_main_value      = 17'sd0;
        o_inbetween_frame = 17'sd0;
        o_frame_delay     = 17'sd0;
        priority if (r_mask[B_SINGLE]) begin
            o_entry_index     = r_bu.idx;
            o_main_value      = r_bu.main_v;
            o_inbetween_frame = r_bu.ib;
            o_frame_delay     = r_bu.dl;
        end else if (r_mask[B_FCOUNT]) begin
            kind         = EV_FRAMECOUNT;
            o_main_value = 17'sd1;
        end else if (r_mask[B_FRAME]) begin
            kind              = EV_FRAME;
            o_main_value      = VAL_NEG1;
            o_inbetween_frame = VAL_NEG1;
            o_frame_delay     = VAL_NEG1;
        end else if (r_mask[B_PRE]) begin
            kind         = EV_PRE;
            o_main_value = r_bu.main_v;
        end else if (r_mask[B_POST]) begin
            kind         = EV_POST;
            o_main_value = r_bu.main_v;
        end else begin
            kind = EV_END;
        end
    end

    assign o_event_kind    = kind;
    assign o_record_number = r_bu.rec;

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_burst.mask;
        end else if (o_valid && i_ready) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bu <= i_burst;
        end
    end

endmodule

`default_nettype wire

// ===== design/srsp_checker.sv =====
// ----------------------------------------------------------------------------
// srsp_checker
// Port-level checks for the sequence record stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_valid,
    input wire                o_ready,
    input wire [7:0]          i_data_byte,
    input wire                i_stream_start,
    input wire                o_valid,
    input wire                i_ready,
    input wire [15:0]         o_record_number,
    input wire [3:0]          o_event_kind,
    input wire [7:0]          o_entry_index,
    input wire signed [16:0]  o_main_value,
    input wire signed [16:0]  o_inbetween_frame,
    input wire signed [16:0]  o_frame_delay,
    input wire                o_last_of_run
);
    import srsp_pkg::*;

    // hold a stalled event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_kind)
            && $stable(o_main_value) && $stable(o_record_number))
        else $error("stalled event changed");

    // an empty result register always takes a byte
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with no pending event");

    // a record end closes its run and carries a zero main value
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_END |-> o_last_of_run && o_main_value == 17'sd0)
        else $error("record end not last of its run");

    // no byte is taken while a multi-event run still has events to show
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> !o_ready)
        else $error("byte accepted in the middle of a run");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("event shown after reset");

endmodule

bind sequence_record_stream_parser srsp_checker u_srsp_checker (.*);

`default_nettype wire
